@@ src/bdfs_pkg.sv @@
`timescale 1ns / 1ps
// bdfs_pkg: constants, register indexes and sequencer step codes
// for the beat-driven frame selector; no dependencies
package bdfs_pkg;

  // default level width, unsigned Q4.12 at 16 bits
  localparam int unsigned LEVEL_BITS_DEF = 16;

  // smoothing and weight coefficients, unsigned Q0.16
  localparam logic [15:0] C_085 = 16'd55706;
  localparam logic [15:0] C_015 = 16'd9830;
  localparam logic [15:0] C_080 = 16'd52429;
  localparam logic [15:0] C_020 = 16'd13107;
  localparam logic [15:0] C_050 = 16'd32768;
  localparam logic [15:0] C_030 = 16'd19661;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_BEAT_FLOOR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BEAT_RATIO   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_ENERGY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MED_ENERGY   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_LIMIT   = 3'd5;

  // register reset values
  localparam logic [15:0] RST_BEAT_FLOOR  = 16'd614;
  localparam logic [9:0]  RST_BEAT_RATIO  = 10'd333;
  localparam logic [15:0] RST_HIGH_ENERGY = 16'd1434;
  localparam logic [15:0] RST_MED_ENERGY  = 16'd614;
  localparam logic [7:0]  RST_HOLD_TICKS  = 8'd6;
  localparam logic [7:0]  RST_IDLE_LIMIT  = 8'd30;

  // sequencer steps: each step before S_DECIDE issues one product, the next one consumes it
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] S_BAVG_OLD = 4'd0;  // bass_avg * 0.85
  localparam logic [STEP_W-1:0] S_BAVG_NEW = 4'd1;  // bass * 0.15
  localparam logic [STEP_W-1:0] S_EN_BASS  = 4'd2;  // finish bass avg, bass * 0.5
  localparam logic [STEP_W-1:0] S_EN_MID   = 4'd3;  // mid * 0.3
  localparam logic [STEP_W-1:0] S_EN_TREB  = 4'd4;  // treble * 0.2
  localparam logic [STEP_W-1:0] S_EAVG_OLD = 4'd5;  // finish energy, energy_avg * 0.8
  localparam logic [STEP_W-1:0] S_EAVG_NEW = 4'd6;  // energy * 0.2
  localparam logic [STEP_W-1:0] S_THRESH   = 4'd7;  // finish energy avg, bass_avg * ratio
  localparam logic [STEP_W-1:0] S_DECIDE   = 4'd8;  // beat test, frame update

  localparam logic [7:0] IDLE_MAX = 8'd255;

endpackage

@@ src/beat_driven_frame_selector.sv @@
`timescale 1ns / 1ps
// beat_driven_frame_selector: top level, one shared multiply-accumulate
// under a nine-step sequencer; depends on bdfs_pkg
//
// Each tick request carries bass, mid and treble levels. The block keeps
// smoothed bass (0.85 old / 0.15 new) and smoothed weighted energy
// (0.5b + 0.3m + 0.2t, then 0.8 old / 0.2 new), flags a beat when bass is
// above both beat_ratio (Q2.8) times the new bass average and beat_floor,
// and steps the animation frame on a beat outside the hold window or when
// the idle count passes idle_limit. Smoothed energy picks the frame set:
// 4..7 above high_energy_level, 0..7 above medium_energy_level, else 0..3.
// All products go through one LEVEL_BITS x 16 multiplier with a registered
// product, followed by one accumulator, so a tick takes nine sequencer steps
// after its accept edge: the block takes no new tick request until the
// current one has finished its last step. The result sits in an output
// register; a new tick is accepted while it still waits, and the sequencer
// only parks in its last step if the previous result has not been taken.
// Configuration is written through a plain write port; write it only while no
// tick is in flight, the block does not enforce this; unused indexes drop writes.
module beat_driven_frame_selector #(
  parameter int unsigned LEVEL_BITS = bdfs_pkg::LEVEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick requests
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // bass_level, mid_level, treble_level from bit 0 up, zero padded
  input  logic [((3*LEVEL_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // results
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // frame_index[2:0], beat_seen[3], frame_changed[4], zero padded
  output logic [7:0]                           m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [bdfs_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [bdfs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import bdfs_pkg::*;

  localparam int unsigned PROD_W = LEVEL_BITS + 16;
  localparam int unsigned ACC_W  = LEVEL_BITS + 18;

  // configuration registers
  logic [15:0] beat_floor_q;
  logic [9:0]  beat_ratio_q;
  logic [15:0] high_level_q;
  logic [15:0] med_level_q;
  logic [7:0]  hold_ticks_q;
  logic [7:0]  idle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_floor_q <= RST_BEAT_FLOOR;
      beat_ratio_q <= RST_BEAT_RATIO;
      high_level_q <= RST_HIGH_ENERGY;
      med_level_q  <= RST_MED_ENERGY;
      hold_ticks_q <= RST_HOLD_TICKS;
      idle_limit_q <= RST_IDLE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BEAT_FLOOR:  beat_floor_q <= cfg_wdata_i;
        REG_BEAT_RATIO:  beat_ratio_q <= cfg_wdata_i[9:0];
        REG_HIGH_ENERGY: high_level_q <= cfg_wdata_i;
        REG_MED_ENERGY:  med_level_q  <= cfg_wdata_i;
        REG_HOLD_TICKS:  hold_ticks_q <= cfg_wdata_i[7:0];
        REG_IDLE_LIMIT:  idle_limit_q <= cfg_wdata_i[7:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // sequencer control
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic              in_acc;
  logic              finish;
  logic              out_free;

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // last step completes only when the output register can take the result
  assign finish        = busy_q && (step_q == S_DECIDE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_BAVG_OLD;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      step_q <= S_BAVG_OLD;
    end else if (finish) begin
      busy_q <= 1'b0;
      step_q <= S_BAVG_OLD;
    end else if (busy_q && step_q != S_DECIDE) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  // captured tick levels, payload only
  logic [LEVEL_BITS-1:0] bass_q, mid_q, treble_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bass_q   <= s_axis_tdata[LEVEL_BITS-1:0];
      mid_q    <= s_axis_tdata[2*LEVEL_BITS-1:LEVEL_BITS];
      treble_q <= s_axis_tdata[3*LEVEL_BITS-1:2*LEVEL_BITS];
    end
  end

  // tick state
  logic [2:0]            frame_q;
  logic [7:0]            hold_q;
  logic [7:0]            idle_q;
  logic [LEVEL_BITS-1:0] bavg_q;
  logic [LEVEL_BITS-1:0] eavg_q;
  logic [LEVEL_BITS-1:0] energy_q;

  // shared multiplier: operand select per step
  logic [LEVEL_BITS-1:0] mul_a;
  logic [15:0]           mul_b;
  logic [PROD_W-1:0]     prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [ACC_W-1:0]      sum;
  logic [LEVEL_BITS-1:0] sum_sat;

  always_comb begin
    unique case (step_q)
      S_BAVG_OLD: begin mul_a = bavg_q;   mul_b = C_085; end
      S_BAVG_NEW: begin mul_a = bass_q;   mul_b = C_015; end
      S_EN_BASS:  begin mul_a = bass_q;   mul_b = C_050; end
      S_EN_MID:   begin mul_a = mid_q;    mul_b = C_030; end
      S_EN_TREB:  begin mul_a = treble_q; mul_b = C_020; end
      S_EAVG_OLD: begin mul_a = eavg_q;   mul_b = C_080; end
      S_EAVG_NEW: begin mul_a = energy_q; mul_b = C_020; end
      S_THRESH:   begin mul_a = bavg_q;   mul_b = {6'd0, beat_ratio_q}; end
      default:    begin mul_a = bavg_q;   mul_b = '0; end
    endcase
  end

  // weighted sum, shift by 16, saturate at full scale
  assign sum     = acc_q + ACC_W'(prod_q);
  assign sum_sat = (|sum[ACC_W-1:LEVEL_BITS+16]) ? {LEVEL_BITS{1'b1}}
                                                  : sum[LEVEL_BITS+15:16];

  always_ff @(posedge clk_i) begin
    if (busy_q && step_q != S_DECIDE) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // accumulator: first product of a sum loads, later ones add
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      unique case (step_q) inside
        S_BAVG_NEW, S_EN_MID, S_EAVG_NEW: acc_q <= ACC_W'(prod_q);
        S_EN_TREB:                        acc_q <= sum;
        default: ;
      endcase
    end
  end

  // beat test and frame decision
  logic [PROD_W-1:0] thresh;
  logic              beat;
  logic [7:0]        hold_dec;
  logic [7:0]        idle_inc;
  logic              change;
  logic [2:0]        frame_nxt;

  assign thresh   = prod_q >> 8;
  assign beat     = (PROD_W'(bass_q) > thresh) && (PROD_W'(bass_q) > PROD_W'(beat_floor_q));
  assign hold_dec = (hold_q != 8'd0) ? hold_q - 8'd1 : hold_q;
  assign idle_inc = (idle_q != IDLE_MAX) ? idle_q + 8'd1 : idle_q;
  assign change   = (beat && hold_dec == 8'd0) || (idle_inc > idle_limit_q);

  always_comb begin
    if (PROD_W'(eavg_q) > PROD_W'(high_level_q)) begin
      // high energy: stay within frames 4..7
      frame_nxt = frame_q[2] ? {1'b1, frame_q[1:0] + 2'd1} : 3'd4;
    end else if (PROD_W'(eavg_q) > PROD_W'(med_level_q)) begin
      frame_nxt = frame_q + 3'd1;
    end else begin
      // low energy: stay within frames 0..3
      frame_nxt = frame_q[2] ? 3'd0 : {1'b0, frame_q[1:0] + 2'd1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      hold_q   <= '0;
      idle_q   <= '0;
      bavg_q   <= '0;
      eavg_q   <= '0;
      energy_q <= '0;
    end else if (busy_q) begin
      unique case (step_q)
        S_EN_BASS:  bavg_q   <= sum_sat;
        S_EAVG_OLD: energy_q <= sum_sat;
        S_THRESH:   eavg_q   <= sum_sat;
        S_DECIDE: begin
          if (finish) begin
            if (change) begin
              frame_q <= frame_nxt;
              idle_q  <= '0;
              hold_q  <= hold_ticks_q;
            end else begin
              idle_q  <= idle_inc;
              hold_q  <= hold_dec;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  logic       out_valid_q;
  logic [2:0] out_frame_q;
  logic       out_beat_q;
  logic       out_change_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_frame_q  <= change ? frame_nxt : frame_q;
      out_beat_q   <= beat;
      out_change_q <= change;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_change_q, out_beat_q, out_frame_q};

  // checks
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= S_DECIDE)
    else $error("sequencer step out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && step_q == S_BAVG_OLD)
    else $error("accepted tick did not start the sequencer");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(finish))
    else $error("result shown without a finished tick");

  a_hold_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && change) |=> hold_q == $past(hold_ticks_q) && idle_q == 8'd0)
    else $error("hold or idle not reloaded on a frame change");

  a_high_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && change && PROD_W'(eavg_q) > PROD_W'(high_level_q)) |=> frame_q[2])
    else $error("high energy change left the upper frame set");

endmodule

@@ dv/beat_driven_frame_selector_tb.sv @@
`timescale 1ns / 1ps
// beat_driven_frame_selector_tb: self-checking bench for the frame selector,
// a directed stimulus table then random ticks under several register settings
// depends on bdfs_pkg and beat_driven_frame_selector
module beat_driven_frame_selector_tb;
  import bdfs_pkg::*;

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_7 = 3'd7;

  // cycles the block may still need after its last result
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [2:0] frame;
    logic       beat;
    logic       changed;
  } frame_result_t;

  // one row of the directed table, exp_res only used when typed is set
  typedef struct packed {
    logic [15:0]   bass;
    logic [15:0]   mid;
    logic [15:0]   treble;
    logic          typed;
    frame_result_t exp_res;
  } tick_row_t;

  localparam int unsigned NUM_ROWS = 20;

  // runs under reset register values; rows 0 and 1 can be read off directly:
  // silence gives nothing, full scale from rest is a beat into the high set
  localparam tick_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    {16'h0000, 16'h0000, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b0},
    {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 3'd4, 1'b1, 1'b1},
    {16'hFFFF, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},  // beat inside hold
    {16'h0000, 16'hFFFF, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0000, 16'h0000, 16'hFFFF, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0001, 16'h0001, 16'h0001, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h5555, 16'hAAAA, 16'h5555, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0000, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0000, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0266, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},  // bass right at the floor
    {16'h0267, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},  // one above the floor
    {16'hFFFF, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h8000, 16'h8000, 16'h8000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0000, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h1000, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'hFFFF, 16'h0000, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 3'd0, 1'b0, 1'b0},
    {16'hFFFF, 16'h1234, 16'hEDCB, 1'b0, 3'd0, 1'b0, 1'b0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;   // bass_level, mid_level, treble_level
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // frame_index, beat_seen, frame_changed
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // predicted selector state and register copy, reset values as in the block
  logic [2:0]  sel_frame = '0;
  logic [7:0]  sel_hold = '0;
  logic [7:0]  sel_idle = '0;
  logic [15:0] bass_avg = '0;
  logic [15:0] energy_avg = '0;
  logic [15:0] cfg_floor = RST_BEAT_FLOOR;
  logic [9:0]  cfg_ratio = RST_BEAT_RATIO;
  logic [15:0] cfg_high = RST_HIGH_ENERGY;
  logic [15:0] cfg_med = RST_MED_ENERGY;
  logic [7:0]  cfg_hold = RST_HOLD_TICKS;
  logic [7:0]  cfg_idle_limit = RST_IDLE_LIMIT;

  // results still owed by the block, oldest first
  frame_result_t pending_frames[$];
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left = 0;

  // receiver stall pattern
  logic [1:0] stall_mode;
  logic [7:0] stall_cyc;

  beat_driven_frame_selector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // saturate a shifted weighted sum at full scale
  function automatic logic [15:0] clip_level(input logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // one tick of the selector: smoothing, beat test, hold/idle, frame step
  function automatic frame_result_t advance_selector(input logic [15:0] bass,
                                                     input logic [15:0] mid,
                                                     input logic [15:0] treble);
    logic [63:0]   sum;
    logic [15:0]   energy;
    logic [25:0]   threshold;
    logic          beat;
    logic          change;
    frame_result_t res;
    sum = 64'(bass_avg) * C_085 + 64'(bass) * C_015;
    bass_avg = clip_level(sum >> 16);
    sum = 64'(bass) * C_050 + 64'(mid) * C_030 + 64'(treble) * C_020;
    energy = clip_level(sum >> 16);
    sum = 64'(energy_avg) * C_080 + 64'(energy) * C_020;
    energy_avg = clip_level(sum >> 16);
    // threshold is kept unsaturated, ratio can push it past full scale
    threshold = (26'(bass_avg) * 26'(cfg_ratio)) >> 8;
    beat = (26'(bass) > threshold) && (bass > cfg_floor);
    if (sel_hold != 0) sel_hold = sel_hold - 8'd1;
    if (sel_idle != IDLE_MAX) sel_idle = sel_idle + 8'd1;
    change = (beat && sel_hold == 0) || (sel_idle > cfg_idle_limit);
    if (change) begin
      // high test wins even when the thresholds are out of order
      if (energy_avg > cfg_high) begin
        sel_frame = sel_frame[2] ? {1'b1, sel_frame[1:0] + 2'd1} : 3'd4;
      end else if (energy_avg > cfg_med) begin
        sel_frame = sel_frame + 3'd1;
      end else begin
        sel_frame = sel_frame[2] ? 3'd0 : {1'b0, sel_frame[1:0] + 2'd1};
      end
      sel_idle = '0;
      sel_hold = cfg_hold;
    end
    res.frame = sel_frame;
    res.beat = beat;
    res.changed = change;
    return res;
  endfunction

  // level mix: silence, full scale, quiet noise, loud levels, anything
  function automatic logic [15:0] rand_level(input logic quiet);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (quiet && pick < 8) return 16'($urandom_range(0, 600));
    case (pick) inside
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 16'h0FFF));
      4, 5:    return 16'($urandom_range(16'h2000, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  // leaves cfg_we_i high, the caller drops it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_BEAT_FLOOR:  cfg_floor = val;
      REG_BEAT_RATIO:  cfg_ratio = val[9:0];
      REG_HIGH_ENERGY: cfg_high = val;
      REG_MED_ENERGY:  cfg_med = val;
      REG_HOLD_TICKS:  cfg_hold = val[7:0];
      REG_IDLE_LIMIT:  cfg_idle_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] floor_v, input logic [15:0] ratio_v,
                            input logic [15:0] high_v, input logic [15:0] med_v,
                            input logic [15:0] hold_v, input logic [15:0] idle_v);
    write_reg(REG_BEAT_FLOOR, floor_v);
    write_reg(REG_UNUSED_6, 16'($urandom));
    write_reg(REG_BEAT_RATIO, ratio_v);
    write_reg(REG_HIGH_ENERGY, high_v);
    write_reg(REG_MED_ENERGY, med_v);
    write_reg(REG_UNUSED_7, 16'($urandom));
    write_reg(REG_HOLD_TICKS, hold_v);
    write_reg(REG_IDLE_LIMIT, idle_v);
    cfg_we_i <= 1'b0;
  endtask

  // one tick request; bursts of random length, random gaps in between
  task automatic send_tick(input logic [15:0] bass, input logic [15:0] mid,
                           input logic [15:0] treble, input logic typed,
                           input frame_result_t typed_res);
    int unsigned   gap;
    frame_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {treble, mid, bass};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    predicted = advance_selector(bass, mid, treble);
    pending_frames.push_back(typed ? typed_res : predicted);
  endtask

  task automatic run_random(input int unsigned count, input logic quiet);
    repeat (count) send_tick(rand_level(quiet), rand_level(quiet), rand_level(quiet),
                             1'b0, '0);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // block is idle once every result is back and the pipeline has had time
  task automatic drain;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: mode is redrawn at random each time the stall counter wraps
  // 0 always ready, 1 coin flip, 2 ready when the low three counter bits are zero, 3 long stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode <= '0;
      stall_cyc <= '0;
    end else begin
      stall_cyc <= stall_cyc + 8'd1;
      if (stall_cyc == 8'hFF) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= (stall_cyc[2:0] == 3'd0);
        default: m_axis_tready <= (stall_cyc[4:0] > 5'd27);
      endcase
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        if (m_axis_tdata[2:0] != want.frame) begin
          $display("%0t: frame_index expected %0d actual %0d", $time, want.frame,
                   m_axis_tdata[2:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[3] != want.beat) begin
          $display("%0t: beat_seen expected %0d actual %0d", $time, want.beat,
                   m_axis_tdata[3]);
          mismatch_count++;
        end
        if (m_axis_tdata[4] != want.changed) begin
          $display("%0t: frame_changed expected %0d actual %0d", $time, want.changed,
                   m_axis_tdata[4]);
          mismatch_count++;
        end
        if (m_axis_tdata[7:5] != 3'd0) begin
          $display("%0t: padding expected 0 actual %0d", $time, m_axis_tdata[7:5]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic quiet;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset register values
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_tick(DIRECTED_ROWS[i].bass, DIRECTED_ROWS[i].mid, DIRECTED_ROWS[i].treble,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp_res);
    end
    s_axis_tvalid <= 1'b0;
    burst_left = 0;

    // random ticks, still reset registers, idle limit forcing shows up here
    run_random(40, 1'b0);

    // all registers at zero: every tick forces a change, hold never blocks
    drain();
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(30, 1'b0);

    // all registers at top: no beat can pass the floor, idle limit 255 is
    // never exceeded, so the idle count saturates and the frame stays put
    drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(270, 1'b0);

    // thresholds out of order, no hold, changes only from beats
    drain();
    set_config(16'd614, 16'd333, 16'd100, 16'd3000, 16'h0000, 16'h00FF);
    run_random(40, 1'b0);

    // random settings, junk in the upper bits of the narrow registers
    repeat (5) begin
      quiet = 1'($urandom_range(0, 1));
      drain();
      set_config(16'($urandom_range(0, 4000)), 16'($urandom),
                 16'($urandom_range(0, 16000)), 16'($urandom_range(0, 16000)),
                 {8'($urandom), 8'($urandom_range(0, 12))},
                 {8'($urandom), 8'($urandom_range(0, 40))});
      run_random(20, quiet);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("beat_driven_frame_selector test passed");
    end else begin
      $display("beat_driven_frame_selector test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("beat_driven_frame_selector test failed");
    $finish;
  end

endmodule
